/* src/gzhp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gzhp_pkg: shared types and constants of the gzip header parser
// Parse phases, result codes and the fixed byte values of a gzip member header.
// ----------------------------------------------------------------------------
package gzhp_pkg;

	// Fixed header byte values
	localparam logic [7:0] MAGIC_ID1      = 8'h1F;
	localparam logic [7:0] MAGIC_ID2      = 8'h8B;
	localparam logic [7:0] METHOD_DEFLATE = 8'h08;
	localparam logic [7:0] FLG_RSVD_MASK  = 8'hE0;

	// Flag bit positions within the flag byte
	localparam int FLG_HCRC    = 1;
	localparam int FLG_EXTRA   = 2;
	localparam int FLG_NAME    = 3;
	localparam int FLG_COMMENT = 4;

	localparam int FLAG_W = 5;
	localparam int SKIP_W = 16;

	// Time, extra flags and OS bytes skipped after the flag byte
	localparam logic [SKIP_W-1:0] FIXED_SKIP = 16'd6;
	localparam logic [SKIP_W-1:0] HCRC_LEN   = 16'd2;

	// Parse phase, one-hot
	typedef enum logic [13:0] {
		PH_MAGIC0  = 14'b00000000000001,
		PH_MAGIC1  = 14'b00000000000010,
		PH_METHOD  = 14'b00000000000100,
		PH_FLAGS   = 14'b00000000001000,
		PH_SKIP6   = 14'b00000000010000,
		PH_XLEN0   = 14'b00000000100000,
		PH_XLEN1   = 14'b00000001000000,
		PH_XDATA   = 14'b00000010000000,
		PH_NAME    = 14'b00000100000000,
		PH_COMMENT = 14'b00001000000000,
		PH_HCRC    = 14'b00010000000000,
		PH_DEFLATE = 14'b00100000000000,
		PH_RAW     = 14'b01000000000000,
		PH_DONE    = 14'b10000000000000
	} phase_t;

	// Optional section at which a section search starts, in header order
	typedef enum logic [1:0] {
		SEC_EXTRA   = 2'd0,
		SEC_NAME    = 2'd1,
		SEC_COMMENT = 2'd2,
		SEC_HCRC    = 2'd3
	} section_t;

	typedef enum logic [2:0] {
		ST_PARSING = 3'd0,
		ST_OK      = 3'd1,
		ST_RAW     = 3'd2,
		ST_ERROR   = 3'd3,
		ST_END     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CL_HEADER  = 2'd0,
		CL_DEFLATE = 2'd1,
		CL_RAW     = 2'd2,
		CL_NONE    = 2'd3
	} class_t;

	// First enabled optional section at or after the given one
	function automatic phase_t first_section(input section_t from,
			input logic [FLAG_W-1:0] flags);
		phase_t ph;
		if (from == SEC_EXTRA && flags[FLG_EXTRA]) begin
			ph = PH_XLEN0;
		end else if (from <= SEC_NAME && flags[FLG_NAME]) begin
			ph = PH_NAME;
		end else if (from <= SEC_COMMENT && flags[FLG_COMMENT]) begin
			ph = PH_COMMENT;
		end else if (flags[FLG_HCRC]) begin
			ph = PH_HCRC;
		end else begin
			ph = PH_DEFLATE;
		end
		return ph;
	endfunction

endpackage

/* src/gzip_header_parser_unit.sv */
`timescale 1ns / 1ps
// Each accepted input beat loads its result beat into the result register.
// Throughput: one byte per cycle if not stalled; the per-byte phase update is a
// single registered step; the result register frees itself when its beat is taken.
// Reset: arst_n clears the parser to expect the first magic byte, with flags,
// counter and status zero, and empties the result register.
// ----------------------------------------------------------------------------
// gzip_header_parser_unit: gzip member header parser
// Strips a gzip member header from a byte stream and passes payload bytes on.
// ----------------------------------------------------------------------------
module gzip_header_parser_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       is_end,
	input  logic       restart,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] byte_class,
	output logic [2:0] status,
	output logic [gzhp_pkg::FLAG_W-1:0] header_flags
);
	import gzhp_pkg::*;

	phase_t              phase_q;
	logic [FLAG_W-1:0]   flags_q;
	logic [SKIP_W-1:0]   skip_q;
	status_t             status_q;

	phase_t              ph_cur, ph_n;
	logic [FLAG_W-1:0]   fl_cur, fl_n;
	logic [SKIP_W-1:0]   sk_cur, sk_n, sk_dec;
	status_t             st_cur, st_n;
	class_t              cls_n;
	logic [7:0]          ob_n;
	logic                enter;
	section_t            enter_from;

	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	class_t              class_q;
	status_t             ostat_q;
	logic [FLAG_W-1:0]   oflags_q;

	logic                accept;

	// Take a new beat whenever the result register is empty or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Apply restart ahead of the beat
	always_comb begin
		if (restart) begin
			ph_cur = PH_MAGIC0;
			fl_cur = '0;
			sk_cur = '0;
			st_cur = ST_PARSING;
		end else begin
			ph_cur = phase_q;
			fl_cur = flags_q;
			sk_cur = skip_q;
			st_cur = status_q;
		end
	end

	assign sk_dec = sk_cur - SKIP_W'(1);

	// Advance the header phase for one beat
	always_comb begin
		ph_n       = ph_cur;
		fl_n       = fl_cur;
		sk_n       = sk_cur;
		st_n       = st_cur;
		cls_n      = CL_HEADER;
		ob_n       = '0;
		enter      = 1'b0;
		enter_from = SEC_EXTRA;
		if (ph_cur == PH_DONE) begin
			cls_n = CL_NONE;
		end else if (is_end) begin
			cls_n = CL_NONE;
			ph_n  = PH_DONE;
			if (ph_cur == PH_MAGIC0 || ph_cur == PH_MAGIC1 ||
					ph_cur == PH_RAW || ph_cur == PH_DEFLATE) begin
				st_n = ST_END;
			end else begin
				st_n = ST_ERROR;
			end
		end else begin
			case (ph_cur)
				PH_MAGIC0: begin
					if (in_byte == MAGIC_ID1) begin
						ph_n = PH_MAGIC1;
					end else begin
						ph_n  = PH_RAW;
						st_n  = ST_RAW;
						cls_n = CL_RAW;
						ob_n  = in_byte;
					end
				end
				PH_MAGIC1: begin
					if (in_byte == MAGIC_ID2) begin
						ph_n = PH_METHOD;
					end else begin
						ph_n  = PH_RAW;
						st_n  = ST_RAW;
						cls_n = CL_RAW;
						ob_n  = in_byte;
					end
				end
				PH_METHOD: begin
					// Hold a bad-method mark in the counter until the flag byte
					sk_n = (in_byte != METHOD_DEFLATE) ? SKIP_W'(1) : '0;
					ph_n = PH_FLAGS;
				end
				PH_FLAGS: begin
					fl_n = in_byte[FLAG_W-1:0];
					if (sk_cur != '0 || (in_byte & FLG_RSVD_MASK) != 8'h00) begin
						st_n = ST_ERROR;
						ph_n = PH_DONE;
					end else begin
						sk_n = FIXED_SKIP;
						ph_n = PH_SKIP6;
					end
				end
				PH_SKIP6: begin
					sk_n       = sk_dec;
					enter      = (sk_dec == '0);
					enter_from = SEC_EXTRA;
				end
				PH_XLEN0: begin
					sk_n = {8'h00, in_byte};
					ph_n = PH_XLEN1;
				end
				PH_XLEN1: begin
					sk_n = {in_byte, sk_cur[7:0]};
					if ({in_byte, sk_cur[7:0]} == '0) begin
						enter      = 1'b1;
						enter_from = SEC_NAME;
					end else begin
						ph_n = PH_XDATA;
					end
				end
				PH_XDATA: begin
					sk_n       = sk_dec;
					enter      = (sk_dec == '0);
					enter_from = SEC_NAME;
				end
				PH_NAME: begin
					enter      = (in_byte == 8'h00);
					enter_from = SEC_COMMENT;
				end
				PH_COMMENT: begin
					enter      = (in_byte == 8'h00);
					enter_from = SEC_HCRC;
				end
				PH_HCRC: begin
					sk_n = sk_dec;
					if (sk_dec == '0) begin
						ph_n = PH_DEFLATE;
						st_n = ST_OK;
					end
				end
				PH_DEFLATE: begin
					cls_n = CL_DEFLATE;
					ob_n  = in_byte;
				end
				PH_RAW: begin
					cls_n = CL_RAW;
					ob_n  = in_byte;
				end
				default: begin
					ph_n  = PH_DONE;
					st_n  = ST_ERROR;
					cls_n = CL_NONE;
				end
			endcase
			// Move on to the next enabled optional section
			if (enter) begin
				ph_n = first_section(enter_from, fl_n);
				if (ph_n == PH_HCRC) begin
					sk_n = HCRC_LEN;
				end
				if (ph_n == PH_DEFLATE) begin
					st_n = ST_OK;
				end
			end
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC0;
			flags_q  <= '0;
			skip_q   <= '0;
			status_q <= ST_PARSING;
		end else if (accept) begin
			phase_q  <= ph_n;
			flags_q  <= fl_n;
			skip_q   <= sk_n;
			status_q <= st_n;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_q <= ob_n;
			class_q    <= cls_n;
			ostat_q    <= st_n;
			oflags_q   <= fl_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign byte_class   = class_q;
	assign status       = ostat_q;
	assign header_flags = oflags_q;

endmodule

/* tb/tb_gzip_header_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gzip_header_parser_unit: self-checking bench for the gzip header parser
// Feeds directed and random byte streams (well-formed members, truncated and
// corrupted headers, raw noise, end marks and restarts) through the valid and
// ready channels. A scoreboard parses every accepted beat in step and compares
// each result beat with its prediction.
// ----------------------------------------------------------------------------
module tb_gzip_header_parser_unit;
	import gzhp_pkg::*;

	typedef struct {
		logic [7:0] data;
		class_t     kind;
		status_t    st;
		logic [4:0] flags;
	} parse_beat_t;

	typedef struct {
		logic [7:0] data;
		logic       e;
		logic       r;
	} stream_item_t;

	// Scoreboard: parses the input stream alongside the block
	class gzhp_scoreboard;
		phase_t            ph;
		logic [4:0]        flg;
		logic [15:0]       cnt;
		status_t           st;
		parse_beat_t       parsed_bytes[$];
		int                mismatches;
		int                compared;
		int                status_hits[5];

		function void clear_parser();
			ph  = PH_MAGIC0;
			flg = '0;
			cnt = '0;
			st  = ST_PARSING;
		endfunction

		function new();
			clear_parser();
			mismatches = 0;
			compared   = 0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		// Move to the first optional section that the flags enable
		function void open_section(section_t from);
			if (from <= SEC_EXTRA && flg[FLG_EXTRA]) begin
				ph = PH_XLEN0;
			end else if (from <= SEC_NAME && flg[FLG_NAME]) begin
				ph = PH_NAME;
			end else if (from <= SEC_COMMENT && flg[FLG_COMMENT]) begin
				ph = PH_COMMENT;
			end else if (flg[FLG_HCRC]) begin
				ph  = PH_HCRC;
				cnt = HCRC_LEN;
			end else begin
				ph = PH_DEFLATE;
				st = ST_OK;
			end
		endfunction

		function void parse_byte(logic [7:0] b, logic e, logic r);
			parse_beat_t res;
			status_t     was;
			res.data = '0;
			res.kind = CL_HEADER;
			if (r)
				clear_parser();
			was = st;
			if (ph == PH_DONE) begin
				res.kind = CL_NONE;
			end else if (e) begin
				res.kind = CL_NONE;
				if (ph == PH_MAGIC0 || ph == PH_MAGIC1 ||
						ph == PH_RAW || ph == PH_DEFLATE)
					st = ST_END;
				else
					st = ST_ERROR;
				ph = PH_DONE;
			end else begin
				case (ph)
				PH_MAGIC0, PH_MAGIC1: begin
					if (b == ((ph == PH_MAGIC0) ? MAGIC_ID1 : MAGIC_ID2)) begin
						ph = (ph == PH_MAGIC0) ? PH_MAGIC1 : PH_METHOD;
					end else begin
						ph       = PH_RAW;
						st       = ST_RAW;
						res.kind = CL_RAW;
						res.data = b;
					end
				end
				PH_METHOD: begin
					// a non-zero count marks a bad method until the flag byte
					cnt = (b != METHOD_DEFLATE) ? 16'd1 : 16'd0;
					ph  = PH_FLAGS;
				end
				PH_FLAGS: begin
					flg = b[4:0];
					if (cnt != 0 || (b & FLG_RSVD_MASK) != 0) begin
						st = ST_ERROR;
						ph = PH_DONE;
					end else begin
						cnt = FIXED_SKIP;
						ph  = PH_SKIP6;
					end
				end
				PH_SKIP6: begin
					cnt = cnt - 1'b1;
					if (cnt == 0)
						open_section(SEC_EXTRA);
				end
				PH_XLEN0: begin
					cnt = {8'h00, b};
					ph  = PH_XLEN1;
				end
				PH_XLEN1: begin
					cnt = {b, cnt[7:0]};
					if (cnt == 0)
						open_section(SEC_NAME);
					else
						ph = PH_XDATA;
				end
				PH_XDATA: begin
					cnt = cnt - 1'b1;
					if (cnt == 0)
						open_section(SEC_NAME);
				end
				PH_NAME: begin
					if (b == 0)
						open_section(SEC_COMMENT);
				end
				PH_COMMENT: begin
					if (b == 0)
						open_section(SEC_HCRC);
				end
				PH_HCRC: begin
					cnt = cnt - 1'b1;
					if (cnt == 0) begin
						ph = PH_DEFLATE;
						st = ST_OK;
					end
				end
				PH_DEFLATE: begin
					res.kind = CL_DEFLATE;
					res.data = b;
				end
				PH_RAW: begin
					res.kind = CL_RAW;
					res.data = b;
				end
				default: begin
					ph       = PH_DONE;
					st       = ST_ERROR;
					res.kind = CL_NONE;
				end
				endcase
			end
			if (st != was)
				status_hits[st]++;
			res.st    = st;
			res.flags = flg;
			parsed_bytes.push_back(res);
		endfunction

		function void compare_parsed(parse_beat_t got);
			parse_beat_t want;
			compared++;
			if (parsed_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result beat: byte %02h class %0d status %0d",
						got.data, got.kind, got.st);
				return;
			end
			want = parsed_bytes.pop_front();
			if (got.data !== want.data || got.kind !== want.kind || got.st !== want.st ||
					got.flags !== want.flags) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: beat %0d expected byte %02h class %s status %s flags %02h",
						compared, want.data, want.kind.name(), want.st.name(), want.flags);
					$display("       got byte %02h class %0d status %0d flags %02h",
						got.data, got.kind, got.st, got.flags);
				end
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       is_end;
	logic       restart;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic [1:0] byte_class;
	logic [2:0] status;
	logic [FLAG_W-1:0] header_flags;

	gzhp_scoreboard sb = new();
	stream_item_t   stream_q[$];
	int             sent;
	int             beats_in;
	bit             calm;

	gzip_header_parser_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.is_end      (is_end),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_class  (byte_class),
		.status      (status),
		.header_flags(header_flags)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Note accepted input beats, then check accepted result beats
	always @(posedge clk) begin
		parse_beat_t got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.parse_byte(in_byte, is_end, restart);
				beats_in++;
			end
			if (out_valid && out_ready) begin
				got.data  = out_byte;
				got.kind  = class_t'(byte_class);
				got.st    = status_t'(status);
				got.flags = header_flags;
				sb.compare_parsed(got);
			end
		end
	end

	// Result side: random stall bursts, one long hold-off, calm at the end
	initial begin
		bit held;
		held = 1'b0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && beats_in >= 150) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (80) @(posedge clk);
			end else if (!calm && ((sb.compared / 90) % 3 != 0) &&
					$urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic push_item(input logic [7:0] b, input logic e, input logic r);
		stream_item_t it;
		it.data = b;
		it.e    = e;
		it.r    = r;
		stream_q.push_back(it);
	endtask

	// Offer one beat, hold it until taken, then maybe idle a burst
	task automatic send_beat(input stream_item_t it);
		in_valid <= 1'b1;
		in_byte  <= it.data;
		is_end   <= it.e;
		restart  <= it.r;
		do @(posedge clk); while (!in_ready);
		sent++;
		calm = (sent >= 600);
		if (!calm && ((sent / 80) % 3 != 1) && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic send_stream();
		while (stream_q.size() != 0)
			send_beat(stream_q.pop_front());
	endtask

	// One gzip member with random content, sometimes corrupted or cut short
	task automatic add_member();
		logic [4:0]  fl;
		logic [15:0] xl;
		int          start;
		int          k;
		int          n;
		start = stream_q.size();
		fl    = 5'($urandom);
		push_item(MAGIC_ID1, 1'b0, 1'b1);
		push_item(MAGIC_ID2, 1'b0, 1'b0);
		push_item(($urandom_range(0, 15) == 0) ? 8'($urandom) : METHOD_DEFLATE,
			1'b0, 1'b0);
		push_item({($urandom_range(0, 15) == 0) ? 3'($urandom_range(1, 7)) : 3'd0, fl},
			1'b0, 1'b0);
		repeat (6) push_item(8'($urandom), 1'b0, 1'b0);
		if (fl[FLG_EXTRA]) begin
			k = $urandom_range(0, 19);
			if (k < 16)
				xl = 16'($urandom_range(0, 8));
			else if (k < 19)
				xl = 16'($urandom_range(0, 255));
			else
				xl = 16'($urandom_range(256, 511));
			push_item(xl[7:0], 1'b0, 1'b0);
			push_item(xl[15:8], 1'b0, 1'b0);
			repeat (xl) push_item(8'($urandom), 1'b0, 1'b0);
		end
		if (fl[FLG_NAME]) begin
			n = $urandom_range(0, 6);
			repeat (n) push_item(8'($urandom_range(1, 255)), 1'b0, 1'b0);
			push_item(8'h00, 1'b0, 1'b0);
		end
		if (fl[FLG_COMMENT]) begin
			n = $urandom_range(0, 6);
			repeat (n) push_item(8'($urandom_range(1, 255)), 1'b0, 1'b0);
			push_item(8'h00, 1'b0, 1'b0);
		end
		if (fl[FLG_HCRC])
			repeat (2) push_item(8'($urandom), 1'b0, 1'b0);
		repeat ($urandom_range(0, 12)) push_item(8'($urandom), 1'b0, 1'b0);
		if ($urandom_range(0, 1) == 0) begin
			push_item(8'($urandom), 1'b1, 1'b0);
			if ($urandom_range(0, 3) == 0)
				push_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
		end
		// cut the member short with an end mark
		if ($urandom_range(0, 5) == 0) begin
			k = $urandom_range(start + 1, stream_q.size() - 1);
			stream_q[k].e = 1'b1;
			while (stream_q.size() > k + 1)
				void'(stream_q.pop_back());
		end
	endtask

	// Restart followed by random bytes, often starting like a magic
	task automatic add_noise();
		int n;
		n = $urandom_range(1, 10);
		push_item(($urandom_range(0, 2) == 0) ? MAGIC_ID1 : 8'($urandom),
			($urandom_range(0, 9) == 0), 1'b1);
		repeat (n) push_item(8'($urandom), ($urandom_range(0, 9) == 0),
			($urandom_range(0, 15) == 0));
	endtask

	// Directed cases: ends, magic mismatch, bad method, reserved flags, empty extra field
	task automatic add_directed();
		push_item(8'hA5, 1'b1, 1'b0);                   // end before any byte
		push_item(8'hFF, 1'b0, 1'b0);                   // byte after sticky end
		push_item(MAGIC_ID1, 1'b0, 1'b1);
		push_item(8'h00, 1'b1, 1'b0);                   // end after first magic
		push_item(MAGIC_ID1, 1'b0, 1'b1);
		push_item(8'h00, 1'b0, 1'b0);                   // second magic wrong
		push_item(8'hFF, 1'b0, 1'b0);
		push_item(8'h3C, 1'b1, 1'b0);                   // end in raw mode
		push_item(8'hFF, 1'b0, 1'b1);                   // first magic wrong
		push_item(MAGIC_ID1, 1'b0, 1'b1);
		push_item(MAGIC_ID2, 1'b0, 1'b0);
		push_item(8'h07, 1'b0, 1'b0);                   // bad method
		push_item(8'h00, 1'b0, 1'b0);
		push_item(MAGIC_ID1, 1'b0, 1'b1);
		push_item(MAGIC_ID2, 1'b0, 1'b0);
		push_item(METHOD_DEFLATE, 1'b0, 1'b0);
		push_item(8'hE0, 1'b0, 1'b0);                   // reserved flags set
		push_item(MAGIC_ID1, 1'b0, 1'b1);
		push_item(MAGIC_ID2, 1'b0, 1'b0);
		push_item(8'hFF, 1'b1, 1'b0);                   // end inside header
		// extra field of length zero, then payload and end
		push_item(MAGIC_ID1, 1'b0, 1'b1);
		push_item(MAGIC_ID2, 1'b0, 1'b0);
		push_item(METHOD_DEFLATE, 1'b0, 1'b0);
		push_item(8'h04, 1'b0, 1'b0);
		repeat (3) begin
			push_item(8'h00, 1'b0, 1'b0);
			push_item(8'hFF, 1'b0, 1'b0);
		end
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'h80, 1'b0, 1'b0);
		push_item(8'h7F, 1'b0, 1'b0);
		push_item(8'h00, 1'b1, 1'b0);                   // end in payload
	endtask

	// Main sequence: reset, directed, random, drain, verdict
	initial begin
		int i;
		int leftover;
		sent     = 0;
		beats_in = 0;
		calm     = 1'b0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_byte  <= 8'h00;
		is_end   <= 1'b0;
		restart  <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_directed();
		send_stream();
		while (sent < 700) begin
			if ($urandom_range(0, 9) < 7)
				add_member();
			else
				add_noise();
			send_stream();
		end
		in_valid <= 1'b0;

		for (i = 0; i < 2000 && sb.parsed_bytes.size() != 0; i++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		leftover = sb.parsed_bytes.size();
		if (leftover != 0)
			$display("ERROR: %0d expected result beats never arrived", leftover);

		$display("Run covered %0d input beats and %0d compared results",
			sent, sb.compared);
		$display("Headers accepted %0d, raw streams %0d, data errors %0d, ends %0d",
			sb.status_hits[ST_OK], sb.status_hits[ST_RAW],
			sb.status_hits[ST_ERROR], sb.status_hits[ST_END]);
		if (sb.mismatches == 0 && leftover == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#5_000_000;
		$display("ERROR: run timed out");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
